/* rtl/slesc_pkg.sv */
`timescale 1ns / 1ps

package slesc_pkg;

    // Decoder modes
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX_HI = 2'd2,
        MODE_HEX_LO = 2'd3
    } t_mode;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_EOF    = 2'd1;
    localparam logic [1:0] ERR_ESCAPE = 2'd2;

    // Raw characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_F   = 8'h46;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_V   = 8'h76;
    localparam logic [7:0] CH_LC_X   = 8'h78;
    localparam logic [7:0] CH_NEWLN  = 8'h0A;

    // Decoded control bytes
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_BEL = 8'h07;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    // One input request
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_item;

    // One result
    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] error_code;
    } t_result;

    // Hex digit value; bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h10;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = c - CH_UC_A + 8'd10;
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = c - CH_LC_A + 8'd10;
        end
        return d[4:0];
    endfunction

endpackage

/* rtl/slesc_in_stage.sv */
`timescale 1ns / 1ps

module slesc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // char_in
    input  logic                 s_axis_tlast,   // end_of_input
    output logic                 o_valid,
    output slesc_pkg::t_item     o_item,
    input  logic                 i_take
);
    import slesc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // Free slot when empty or emptying this cycle
    assign s_axis_tready = !r_valid || i_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.char_in      <= s_axis_tdata;
            r_item.end_of_input <= s_axis_tlast;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/slesc_core.sv */
`timescale 1ns / 1ps

module slesc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  slesc_pkg::t_item     i_item,
    output logic                 o_take,
    output logic                 o_valid,
    output slesc_pkg::t_result   o_result,
    input  logic                 i_ready
);
    import slesc_pkg::*;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [3:0] r_high_nibble;
    logic [3:0] n_high_nibble;
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_result;
    t_result    n_result;
    logic [4:0] w_hex;

    // Advance when the result slot is free or being drained
    assign o_take = i_valid && (!r_out_valid || i_ready);
    assign w_hex  = hex_value(i_item.char_in);

    // Next mode and saved nibble
    always_comb begin
        n_mode        = r_mode;
        n_high_nibble = r_high_nibble;
        if (i_item.end_of_input) begin
            n_mode = MODE_NORMAL;
        end else begin
            case (r_mode)
                MODE_NORMAL: begin
                    if (i_item.char_in == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE: begin
                    n_mode = (i_item.char_in == CH_LC_X) ? MODE_HEX_HI : MODE_NORMAL;
                end
                MODE_HEX_HI: begin
                    if (!w_hex[4]) begin
                        n_high_nibble = w_hex[3:0];
                        n_mode        = MODE_HEX_LO;
                    end else begin
                        n_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    n_mode = MODE_NORMAL;
                end
            endcase
        end
    end

    // Result fields
    always_comb begin
        n_result = '0;
        if (i_item.end_of_input) begin
            n_result.error_code = ERR_EOF;
        end else begin
            case (r_mode)
                MODE_NORMAL: begin
                    if (i_item.char_in == CH_QUOTE) begin
                        n_result.string_done = 1'b1;
                    end else if (i_item.char_in != CH_BSLASH) begin
                        n_result.byte_out   = i_item.char_in;
                        n_result.byte_valid = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    n_result.byte_valid = 1'b1;
                    case (i_item.char_in)
                        CH_QUOTE:  n_result.byte_out = CH_QUOTE;
                        CH_BSLASH: n_result.byte_out = CH_BSLASH;
                        CH_ZERO:   n_result.byte_out = BYTE_NUL;
                        CH_LC_F:   n_result.byte_out = BYTE_FF;
                        CH_LC_N:   n_result.byte_out = BYTE_LF;
                        CH_LC_R:   n_result.byte_out = BYTE_CR;
                        CH_LC_T:   n_result.byte_out = BYTE_TAB;
                        CH_LC_A:   n_result.byte_out = BYTE_BEL;
                        CH_LC_V:   n_result.byte_out = BYTE_VT;
                        CH_NEWLN, CH_LC_X: begin
                            n_result.byte_valid = 1'b0;
                        end
                        default: begin
                            n_result.byte_valid = 1'b0;
                            n_result.error_code = ERR_ESCAPE;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    if (w_hex[4]) begin
                        n_result.error_code = ERR_ESCAPE;
                    end
                end
                default: begin
                    if (!w_hex[4]) begin
                        n_result.byte_out   = {r_high_nibble, w_hex[3:0]};
                        n_result.byte_valid = 1'b1;
                    end else begin
                        n_result.error_code = ERR_ESCAPE;
                    end
                end
            endcase
        end
    end

    // Result slot occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_NORMAL;
            r_high_nibble <= 4'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_mode        <= n_mode;
                r_high_nibble <= n_high_nibble;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

/* rtl/string_literal_escape_decoder_unit.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata             tuser                         tlast
// s_axis    in   char_in [7:0]     -                             end_of_input
// m_axis    out  byte_out [7:0]    byte_valid, error_code [2:1]  string_done
//
// One request in, exactly one result out, one request per cycle sustained while m_axis_tready stays high.
// The path has two registers: the input register, then the decode logic, with the
// mode/nibble registers updating as the result register loads.
// Synchronous active-low reset empties both stages and returns to normal mode.
// A stalled output holds its result while the input register still takes one
// more request; further requests wait on s_axis_tready.
module string_literal_escape_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] byte_out
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [2:1] error_code
    output logic       m_axis_tlast    // string_done
);
    import slesc_pkg::*;

    logic    w_in_valid;
    t_item   w_item;
    logic    w_take;
    t_result w_result;

    slesc_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_valid       (w_in_valid),
        .o_item        (w_item),
        .i_take        (w_take)
    );

    slesc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_in_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .o_result (w_result),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = w_result.byte_out;
    assign m_axis_tuser = {w_result.error_code, w_result.byte_valid};
    assign m_axis_tlast = w_result.string_done;

endmodule

/* tb/tb_string_literal_escape_decoder_unit.sv */
`timescale 1ns / 1ps

module tb_string_literal_escape_decoder_unit;
    import slesc_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 950;
    localparam int DIR_ROWS = 24;

    // One stimulus row; exp is used only when typed is set
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        t_result    exp;
    } t_stim;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] char_in
    logic       s_axis_tlast;   // end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] byte_out
    logic [2:0] m_axis_tuser;   // [0] byte_valid, [2:1] error_code
    logic       m_axis_tlast;   // string_done

    // Decoder mirror state
    t_mode      pred_mode = MODE_NORMAL;
    logic [3:0] pred_nibble = 4'h0;

    t_stim   char_stream[$];
    t_result pending_results[$];
    int      n_taken = 0;
    int      n_results = 0;
    int      n_errors = 0;
    int      idle_cycles = 0;
    bit      calm_tx = 1'b0;
    bit      calm_rx = 1'b0;

    // Directed rows: extremes, several escape kinds, errors, continuation, done
    t_stim dir_tab [DIR_ROWS] = '{
        '{CH_UC_A,   1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, ERR_NONE}},
        '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_NONE}},
        '{8'hFF,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_EOF}},
        '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, ERR_NONE}},
        '{CH_BSLASH, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_NONE}},
        '{CH_LC_N,   1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_LC_T,   1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_LC_X,   1'b0, 1'b0, '0},
        '{CH_UC_F,   1'b0, 1'b0, '0},
        '{CH_LC_F,   1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{8'h71,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_ESCAPE}},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_NEWLN,  1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_NONE}},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_LC_X,   1'b0, 1'b0, '0},
        '{8'h67,     1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_ESCAPE}},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{8'h00,     1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, ERR_EOF}},
        '{CH_QUOTE,  1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, ERR_NONE}}
    };

    string_literal_escape_decoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Hex digit value; bit 4 flags a non-digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[CH_UC_A:CH_UC_F]} || c inside {[CH_LC_A:CH_LC_F]}) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Decode one character against the mirror state
    task automatic decode_char(input logic [7:0] ch, input logic eoi, output t_result r);
        logic [4:0] d;
        r = '0;
        d = hex_digit(ch);
        if (eoi) begin
            r.error_code = ERR_EOF;
            pred_mode = MODE_NORMAL;
        end else begin
            case (pred_mode)
                MODE_NORMAL: begin
                    if (ch == CH_QUOTE) begin
                        r.string_done = 1'b1;
                    end else if (ch == CH_BSLASH) begin
                        pred_mode = MODE_ESCAPE;
                    end else begin
                        r.byte_out = ch;
                        r.byte_valid = 1'b1;
                    end
                end
                MODE_ESCAPE: begin
                    pred_mode = MODE_NORMAL;
                    r.byte_valid = 1'b1;
                    case (ch)
                        CH_QUOTE:  r.byte_out = CH_QUOTE;
                        CH_BSLASH: r.byte_out = CH_BSLASH;
                        CH_ZERO:   r.byte_out = BYTE_NUL;
                        CH_LC_F:   r.byte_out = BYTE_FF;
                        CH_LC_N:   r.byte_out = BYTE_LF;
                        CH_LC_R:   r.byte_out = BYTE_CR;
                        CH_LC_T:   r.byte_out = BYTE_TAB;
                        CH_LC_A:   r.byte_out = BYTE_BEL;
                        CH_LC_V:   r.byte_out = BYTE_VT;
                        CH_NEWLN:  r.byte_valid = 1'b0;
                        CH_LC_X: begin
                            r.byte_valid = 1'b0;
                            pred_mode = MODE_HEX_HI;
                        end
                        default: begin
                            r.byte_valid = 1'b0;
                            r.error_code = ERR_ESCAPE;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    if (!d[4]) begin
                        pred_nibble = d[3:0];
                        pred_mode = MODE_HEX_LO;
                    end else begin
                        r.error_code = ERR_ESCAPE;
                        pred_mode = MODE_NORMAL;
                    end
                end
                default: begin
                    pred_mode = MODE_NORMAL;
                    if (!d[4]) begin
                        r.byte_out = {pred_nibble, d[3:0]};
                        r.byte_valid = 1'b1;
                    end else begin
                        r.error_code = ERR_ESCAPE;
                    end
                end
            endcase
        end
    endtask

    task automatic add_char(input logic [7:0] ch, input logic eoi);
        t_stim s;
        s = '0;
        s.ch = ch;
        s.eoi = eoi;
        char_stream.push_back(s);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return CH_ZERO + 8'(v);
        end
        if ($urandom_range(0, 1) == 0) begin
            return CH_UC_A + 8'(v - 10);
        end
        return CH_LC_A + 8'(v - 10);
    endfunction

    // Plain character: anything but quote and backslash
    function automatic logic [7:0] rand_plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // Random strings: mostly well-formed tokens, some broken escapes and noise
    task automatic build_random(input int count);
        logic [7:0] simple_esc [9];
        int r;
        int limit;
        simple_esc = '{CH_QUOTE, CH_BSLASH, CH_ZERO, CH_LC_F, CH_LC_N,
                       CH_LC_R, CH_LC_T, CH_LC_A, CH_LC_V};
        limit = char_stream.size() + count;
        while (char_stream.size() < limit) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_char(rand_plain_char(), 1'b0);
            end else if (r < 55) begin
                add_char(CH_BSLASH, 1'b0);
                add_char(simple_esc[$urandom_range(0, 8)], 1'b0);
            end else if (r < 70) begin
                add_char(CH_BSLASH, 1'b0);
                add_char(CH_LC_X, 1'b0);
                // occasional bad digit in either position
                add_char($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                   : rand_hex_char(), 1'b0);
                add_char($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                   : rand_hex_char(), 1'b0);
            end else if (r < 75) begin
                add_char(CH_BSLASH, 1'b0);
                add_char(CH_NEWLN, 1'b0);
            end else if (r < 82) begin
                add_char(CH_QUOTE, 1'b0);
            end else if (r < 85) begin
                add_char(8'($urandom_range(0, 255)), 1'b1);
            end else if (r < 90) begin
                add_char(CH_BSLASH, 1'b0);
                add_char(8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 93) begin
                // source ends inside an escape
                add_char(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    add_char(CH_LC_X, 1'b0);
                    if ($urandom_range(0, 1) == 1) begin
                        add_char(rand_hex_char(), 1'b0);
                    end
                end
                add_char(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 n_results, what, want, got);
        n_errors++;
    endtask

    // Scoreboard: check results, predict on each accepted request
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result calc;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.byte_out = m_axis_tdata;
                got.byte_valid = m_axis_tuser[0];
                got.error_code = m_axis_tuser[2:1];
                got.string_done = m_axis_tlast;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, int'(got));
                end else begin
                    want = pending_results.pop_front();
                    if (got.byte_out != want.byte_out)
                        report_mismatch("byte_out", want.byte_out, got.byte_out);
                    if (got.byte_valid != want.byte_valid)
                        report_mismatch("byte_valid", want.byte_valid, got.byte_valid);
                    if (got.string_done != want.string_done)
                        report_mismatch("string_done", want.string_done, got.string_done);
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", want.error_code, got.error_code);
                end
                n_results++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_char(s_axis_tdata, s_axis_tlast, calc);
                if (char_stream[n_taken].typed) begin
                    pending_results.push_back(char_stream[n_taken].exp);
                end else begin
                    pending_results.push_back(calc);
                end
                n_taken++;
            end
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side backpressure
    initial begin
        int stall;
        int run;
        m_axis_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                calm_rx = !calm_rx;
            end
            stall = calm_rx ? 0 : pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                              : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
        end
    end

    // Reset, request driver, end of run
    initial begin
        int gap;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;

        for (int k = 0; k < DIR_ROWS; k++) begin
            char_stream.push_back(dir_tab[k]);
        end
        build_random(RANDOM_ITEMS);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < char_stream.size(); k++) begin
            if (k % 64 == 0) begin
                calm_tx = ($urandom_range(0, 3) == 0);
            end
            gap = calm_tx ? 0 : pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= char_stream[k].ch;
            s_axis_tlast <= char_stream[k].eoi;
            do @(posedge i_clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;

        // Drain: all requests taken and every result seen
        do @(negedge i_clk);
        while (n_taken < char_stream.size() || pending_results.size() != 0);
        repeat (8) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
